FILE: rtl/asl_pkg.sv
// ----------------------------------------------------------------------------
// asl_pkg: shared types and constants of the assembler line lexer
// input and result item layouts, result kinds, token types and error codes
// ----------------------------------------------------------------------------
package asl_pkg;

  localparam int VALUE_BITS = 32;
  localparam int LINE_BITS  = 16;

  localparam logic [7:0] COMMENT_RESET = 8'h3B;  // ';'
  localparam logic [7:0] ASCII_MAX     = 8'd127;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_END   = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    TT_KEYWORD = 2'd0,
    TT_NUMBER  = 2'd1,
    TT_STRING  = 2'd2,
    TT_DIVIDER = 2'd3
  } ttype_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_CHAR   = 2'd1,
    ERR_NUMBER = 2'd2,
    ERR_STRING = 2'd3
  } err_t;

  typedef struct packed {
    logic [7:0] char_in;
    logic       line_end;
  } in_t;

  typedef struct packed {
    kind_t                 kind;
    ttype_t                token_type;
    logic [7:0]            char_out;
    logic [VALUE_BITS-1:0] number_value;
    err_t                  error_code;
    logic [LINE_BITS-1:0]  line_no;
    logic                  line_nonempty;
    logic                  last;
  } out_t;

endpackage

FILE: rtl/assembler_line_lexer.sv
// ----------------------------------------------------------------------------
// assembler_line_lexer: character-serial lexer for assembly source lines
// splits lines into keyword, number, string and divider tokens, one byte per item
// ----------------------------------------------------------------------------
//
//  channel   | signals                               | direction | meaning
//  ----------+---------------------------------------+-----------+--------------------
//  char      | char_valid, char_stall, char_item     | in        | one byte or line end
//  tok       | tok_valid, tok_stall, tok_item        | out       | token chars / ends
//  comment   | comment_we, comment_wdata             | in        | comment character
//
//  an item is decoded in the cycle it is accepted; its zero to three results land
//  in a four-entry result queue and the first shows on tok the next cycle if none wait
//  one item per cycle while items give at most one result each and tok does not stall;
//  an item with several results holds the output until all are taken, the single port sets that pace
//  char_stall is high while two or more results wait in the queue
//  rst (synchronous) clears the lexer state, the queue and sets comment char to ';'
//  after an error result the block swallows every item until reset
//
module assembler_line_lexer (
  input  logic          clk,
  input  logic          rst,
  input  logic          comment_we,
  input  logic [7:0]    comment_wdata,
  input  logic          char_valid,
  output logic          char_stall,
  input  asl_pkg::in_t  char_item,
  output logic          tok_valid,
  input  logic          tok_stall,
  output asl_pkg::out_t tok_item
);
  import asl_pkg::*;

  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
  localparam logic [LINE_BITS-1:0]  LINE_MAX  = '1;

  // lexer state
  logic [7:0]            comment_char;
  logic                  in_string, in_string_next;
  logic [7:0]            quote_char, quote_char_next;
  ttype_t                cur_type, cur_type_next;
  logic                  token_open, token_open_next;
  logic                  hex_letter_seen, hex_letter_seen_next;
  logic                  suffix_seen, suffix_seen_next;
  logic                  last_was_suffix, last_was_suffix_next;
  logic [VALUE_BITS-1:0] dec_acc, dec_acc_next;
  logic                  dec_done, dec_done_next;
  logic [VALUE_BITS-1:0] hex_acc, hex_acc_next;
  logic                  hex_done, hex_done_next;
  logic                  in_comment, in_comment_next;
  logic                  line_had_token, line_had_token_next;
  logic [LINE_BITS-1:0]  line_count, line_count_next;
  logic                  halted, halted_next;

  // result queue, head at entry 0
  out_t       q [4];
  out_t       q_next [4];
  logic [2:0] cnt, cnt_next;

  // step signals
  logic       accept, pop;
  logic [7:0] c;
  logic       is_quote, is_comment, is_high, is_space, is_div;
  logic       is_alpha, is_dig, is_hl, is_h, is_upper;
  logic       closing, close_fail, close_ok;
  logic [VALUE_BITS-1:0] close_val;
  ttype_t     eff_type;
  logic       n_hls, n_sfx, n_lws, n_ddone, n_hdone;
  logic [VALUE_BITS-1:0] n_dacc, n_hacc;
  logic [3:0] hex_digit;
  logic [7:0] ch_out;
  out_t       res [3];
  logic [1:0] n;
  logic [2:0] cnt_base;
  logic [2:0] rel;

  function automatic out_t mk(kind_t k, ttype_t t, logic [7:0] ch,
                              logic [VALUE_BITS-1:0] v, err_t e, logic ne,
                              logic [LINE_BITS-1:0] ln);
    out_t r;
    r.kind          = k;
    r.token_type    = t;
    r.char_out      = ch;
    r.number_value  = v;
    r.error_code    = e;
    r.line_no       = ln;
    r.line_nonempty = ne;
    r.last          = 1'b0;
    return r;
  endfunction

  // acc * 10 + d, saturating
  function automatic logic [VALUE_BITS-1:0] sat_dec(logic [VALUE_BITS-1:0] acc,
                                                    logic [3:0] d);
    logic [VALUE_BITS+3:0] w;
    w = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{VALUE_BITS{1'b0}}, d};
    return (w[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? VALUE_MAX : w[VALUE_BITS-1:0];
  endfunction

  // acc * 16 + d, saturating
  function automatic logic [VALUE_BITS-1:0] sat_hex(logic [VALUE_BITS-1:0] acc,
                                                    logic [3:0] d);
    return (acc[VALUE_BITS-1:VALUE_BITS-4] != 4'd0) ? VALUE_MAX
                                                    : {acc[VALUE_BITS-5:0], d};
  endfunction

  // handshakes: room for three new results whenever at most one waits
  assign char_stall = (cnt > 3'd1);
  assign accept     = char_valid && !char_stall;
  assign tok_valid  = (cnt != 3'd0);
  assign pop        = tok_valid && !tok_stall;
  assign tok_item   = q[0];

  // character classes
  assign c          = char_item.char_in;
  assign is_quote   = (c == 8'd39) || (c == 8'd34);
  assign is_comment = (c == comment_char);
  assign is_high    = (c > ASCII_MAX);
  assign is_space   = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  assign is_div     = (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                      (c >= 8'd91 && c <= 8'd96 && c != 8'd95) ||
                      (c >= 8'd123 && c <= 8'd126);
  assign is_upper   = (c >= 8'd65 && c <= 8'd90);
  assign is_alpha   = is_upper || (c >= 8'd97 && c <= 8'd122) || (c == 8'd95);
  assign is_dig     = (c >= 8'd48 && c <= 8'd57);
  assign is_hl      = (c >= 8'd97 && c <= 8'd102) || (c >= 8'd65 && c <= 8'd70);
  assign is_h       = (c == 8'd104) || (c == 8'd72);
  // letters a..f and A..F have their value as low three bits plus nine
  assign hex_digit  = is_dig ? c[3:0] : ({1'b0, c[2:0]} + 4'd9);

  // the open token is closed first by a line end, quote, comment char,
  // whitespace or divider
  assign closing = accept && !halted &&
                   (char_item.line_end ? !in_string
                    : (!in_comment && !in_string &&
                       (is_quote || is_comment || is_space || is_div)));
  assign close_fail = (cur_type == TT_NUMBER) && hex_letter_seen && !suffix_seen;
  assign close_val  = (cur_type == TT_NUMBER) ? (last_was_suffix ? hex_acc : dec_acc)
                                              : '0;
  assign eff_type   = token_open ? cur_type : (is_alpha ? TT_KEYWORD : TT_NUMBER);

  // one input item: state update and up to three results
  always_comb begin
    in_string_next       = in_string;
    quote_char_next      = quote_char;
    cur_type_next        = cur_type;
    token_open_next      = token_open;
    hex_letter_seen_next = hex_letter_seen;
    suffix_seen_next     = suffix_seen;
    last_was_suffix_next = last_was_suffix;
    dec_acc_next         = dec_acc;
    dec_done_next        = dec_done;
    hex_acc_next         = hex_acc;
    hex_done_next        = hex_done;
    in_comment_next      = in_comment;
    line_had_token_next  = line_had_token;
    line_count_next      = line_count;
    halted_next          = halted;
    for (int i = 0; i < 3; i++) res[i] = '0;
    n        = 2'd0;
    close_ok = 1'b1;
    // number scan starts fresh when this byte opens the token
    n_hls    = token_open && hex_letter_seen;
    n_sfx    = token_open && suffix_seen;
    n_lws    = token_open && last_was_suffix;
    n_ddone  = token_open && dec_done;
    n_hdone  = token_open && hex_done;
    n_dacc   = token_open ? dec_acc : '0;
    n_hacc   = token_open ? hex_acc : '0;
    ch_out   = (eff_type == TT_KEYWORD && is_upper) ? (c + 8'd32) : c;

    if (closing && token_open) begin
      if (close_fail) begin
        res[n] = mk(KIND_ERROR, TT_KEYWORD, 8'd0, '0, ERR_NUMBER, 1'b0, line_count);
        n = n + 2'd1;
        halted_next = 1'b1;
        close_ok = 1'b0;
      end else begin
        res[n] = mk(KIND_END, cur_type, 8'd0, close_val, ERR_NONE, 1'b0, line_count);
        n = n + 2'd1;
        token_open_next = 1'b0;
        line_had_token_next = 1'b1;
      end
    end

    if (accept && !halted && close_ok) begin
      if (char_item.line_end) begin
        if (in_string) begin
          res[n] = mk(KIND_ERROR, TT_KEYWORD, 8'd0, '0, ERR_STRING, 1'b0, line_count);
          n = n + 2'd1;
          halted_next = 1'b1;
        end else begin
          res[n] = mk(KIND_LINE, TT_KEYWORD, 8'd0, '0, ERR_NONE,
                      line_had_token_next, line_count);
          n = n + 2'd1;
          if (line_count != LINE_MAX) line_count_next = line_count + LINE_BITS'(1);
          in_comment_next     = 1'b0;
          line_had_token_next = 1'b0;
          token_open_next     = 1'b0;
          cur_type_next       = TT_KEYWORD;
        end
      end else if (in_comment) begin
        // rest of line dropped
      end else if (in_string) begin
        if (c == quote_char) begin
          res[n] = mk(KIND_END, TT_STRING, 8'd0, '0, ERR_NONE, 1'b0, line_count);
          n = n + 2'd1;
          in_string_next      = 1'b0;
          line_had_token_next = 1'b1;
        end else begin
          res[n] = mk(KIND_CHAR, TT_STRING, c, '0, ERR_NONE, 1'b0, line_count);
          n = n + 2'd1;
        end
      end else if (is_quote) begin
        in_string_next  = 1'b1;
        quote_char_next = c;
        cur_type_next   = TT_STRING;
      end else if (is_comment) begin
        in_comment_next = 1'b1;
      end else if (is_high) begin
        res[n] = mk(KIND_ERROR, TT_KEYWORD, 8'd0, '0, ERR_CHAR, 1'b0, line_count);
        n = n + 2'd1;
        halted_next = 1'b1;
      end else if (is_space) begin
        // token already closed
      end else if (is_div) begin
        cur_type_next = TT_DIVIDER;
        res[n] = mk(KIND_CHAR, TT_DIVIDER, c, '0, ERR_NONE, 1'b0, line_count);
        n = n + 2'd1;
        res[n] = mk(KIND_END, TT_DIVIDER, 8'd0, '0, ERR_NONE, 1'b0, line_count);
        n = n + 2'd1;
        line_had_token_next = 1'b1;
      end else if (!is_alpha && !is_dig) begin
        res[n] = mk(KIND_ERROR, TT_KEYWORD, 8'd0, '0, ERR_CHAR, 1'b0, line_count);
        n = n + 2'd1;
        halted_next = 1'b1;
      end else begin
        token_open_next = 1'b1;
        cur_type_next   = eff_type;
        if (eff_type == TT_NUMBER && is_h && n_sfx) begin
          // second suffix
          res[n] = mk(KIND_ERROR, TT_KEYWORD, 8'd0, '0, ERR_NUMBER, 1'b0, line_count);
          n = n + 2'd1;
          halted_next = 1'b1;
        end else begin
          if (eff_type == TT_NUMBER) begin
            if (!n_ddone) begin
              if (is_dig) n_dacc = sat_dec(n_dacc, c[3:0]);
              else n_ddone = 1'b1;
            end
            if (!n_hdone) begin
              if (is_dig || is_hl) n_hacc = sat_hex(n_hacc, hex_digit);
              else n_hdone = 1'b1;
            end
            if (is_hl) begin
              n_hls = 1'b1;
              n_lws = 1'b0;
            end else if (is_h) begin
              n_sfx = 1'b1;
              n_lws = 1'b1;
            end else begin
              n_lws = 1'b0;
            end
            hex_letter_seen_next = n_hls;
            suffix_seen_next     = n_sfx;
            last_was_suffix_next = n_lws;
            dec_acc_next         = n_dacc;
            dec_done_next        = n_ddone;
            hex_acc_next         = n_hacc;
            hex_done_next        = n_hdone;
          end
          res[n] = mk(KIND_CHAR, eff_type, ch_out, '0, ERR_NONE, 1'b0, line_count);
          n = n + 2'd1;
        end
      end
    end

    // the final result of an item carries the last mark
    if (accept && !halted && (closing || n != 2'd0)) begin
      if (n != 2'd0) res[n - 2'd1].last = 1'b1;
    end
  end

  // result queue: drop the head on a pop, append the new results behind
  always_comb begin
    cnt_base = cnt - {2'd0, pop};
    for (int i = 0; i < 3; i++) q_next[i] = pop ? q[i+1] : q[i];
    q_next[3] = q[3];
    for (int i = 0; i < 4; i++) begin
      rel = 3'(i) - cnt_base;
      if (3'(i) >= cnt_base && rel < {1'b0, n}) q_next[i] = res[rel[1:0]];
    end
    cnt_next = cnt_base + {1'b0, n};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) q[i] <= q_next[i];
    if (rst) begin
      cnt             <= 3'd0;
      comment_char    <= COMMENT_RESET;
      in_string       <= 1'b0;
      quote_char      <= 8'd0;
      cur_type        <= TT_KEYWORD;
      token_open      <= 1'b0;
      hex_letter_seen <= 1'b0;
      suffix_seen     <= 1'b0;
      last_was_suffix <= 1'b0;
      dec_acc         <= '0;
      dec_done        <= 1'b0;
      hex_acc         <= '0;
      hex_done        <= 1'b0;
      in_comment      <= 1'b0;
      line_had_token  <= 1'b0;
      line_count      <= {{(LINE_BITS-1){1'b0}}, 1'b1};
      halted          <= 1'b0;
    end else begin
      cnt             <= cnt_next;
      if (comment_we) comment_char <= comment_wdata;
      in_string       <= in_string_next;
      quote_char      <= quote_char_next;
      cur_type        <= cur_type_next;
      token_open      <= token_open_next;
      hex_letter_seen <= hex_letter_seen_next;
      suffix_seen     <= suffix_seen_next;
      last_was_suffix <= last_was_suffix_next;
      dec_acc         <= dec_acc_next;
      dec_done        <= dec_done_next;
      hex_acc         <= hex_acc_next;
      hex_done        <= hex_done_next;
      in_comment      <= in_comment_next;
      line_had_token  <= line_had_token_next;
      line_count      <= line_count_next;
      halted          <= halted_next;
    end
  end

  // an error is always the newest result in the queue
  a_error_tail: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_item.kind == KIND_ERROR) |-> (cnt == 3'd1))
    else $error("result queued behind an error");

  // an error result closes its item
  a_error_last: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_item.kind == KIND_ERROR) |-> tok_item.last)
    else $error("error result without last mark");

  // once halted, no new results enter the queue
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    halted |=> (cnt <= $past(cnt)))
    else $error("results produced while halted");

  // the line flag only rides on line end results
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    (tok_valid && tok_item.kind != KIND_LINE) |-> !tok_item.line_nonempty)
    else $error("line_nonempty set outside a line end");

endmodule
